/* src/dart_pkg.sv */
`default_nettype none

package dart_pkg;

  // item kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // bus addresses
  localparam logic [15:0] ADDR_DIV     = 16'hFF04;
  localparam logic [15:0] ADDR_COUNT   = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam int unsigned DIV_W      = 8;
  localparam int unsigned PRESCALE_W = 11;
  localparam int unsigned ENABLE_BIT = 2;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;

  // periods in ticks of the base clock
  localparam int unsigned BASE_CLK_HZ = 4194304;
  localparam logic [PRESCALE_W-1:0] PERIOD_SEL0 = PRESCALE_W'(BASE_CLK_HZ / 4096);
  localparam logic [PRESCALE_W-1:0] PERIOD_SEL1 = PRESCALE_W'(BASE_CLK_HZ / 262144);
  localparam logic [PRESCALE_W-1:0] PERIOD_SEL2 = PRESCALE_W'(BASE_CLK_HZ / 65536);
  localparam logic [PRESCALE_W-1:0] PERIOD_SEL3 = PRESCALE_W'(BASE_CLK_HZ / 16384);

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
  } out_word_t;

  function automatic logic [PRESCALE_W-1:0] period_of(input logic [1:0] sel);
    logic [PRESCALE_W-1:0] p;
    unique case (sel)
      2'd0: p = PERIOD_SEL0;
      2'd1: p = PERIOD_SEL1;
      2'd2: p = PERIOD_SEL2;
      default: p = PERIOD_SEL3;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* src/dart_core.sv */
`default_nettype none

module dart_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 go,
  input  dart_pkg::in_word_t  item,
  output dart_pkg::out_word_t res
);

  logic [7:0]                          div_val_r,   div_val_nxt;
  logic [7:0]                          div_pre_r,   div_pre_nxt;
  logic [7:0]                          count_r,     count_nxt;
  logic [7:0]                          modulo_r,    modulo_nxt;
  logic [7:0]                          control_r,   control_nxt;
  logic [dart_pkg::PRESCALE_W-1:0]     cnt_pre_r,   cnt_pre_nxt;
  logic [dart_pkg::PRESCALE_W-1:0]     period_r,    period_nxt;
  logic [dart_pkg::PRESCALE_W-1:0]     pre_inc;
  logic                                irq;
  logic [7:0]                          rd;

  always_comb begin
    div_val_nxt = div_val_r;
    div_pre_nxt = div_pre_r;
    count_nxt   = count_r;
    modulo_nxt  = modulo_r;
    control_nxt = control_r;
    cnt_pre_nxt = cnt_pre_r;
    period_nxt  = period_r;
    pre_inc     = cnt_pre_r + 1'b1;
    irq         = 1'b0;
    rd          = 8'd0;
    unique case (item.mode)
      dart_pkg::MODE_TICK: begin
        div_pre_nxt = div_pre_r + 1'b1;
        if (div_pre_r == 8'hFF) begin
          div_val_nxt = div_val_r + 1'b1;
        end
        if (control_r[dart_pkg::ENABLE_BIT]) begin
          // prescaler wraps modulo 2048 and is compared after the bump
          if (pre_inc == period_r) begin
            cnt_pre_nxt = '0;
            if (count_r == dart_pkg::COUNT_MAX) begin
              count_nxt = modulo_r;
              irq       = 1'b1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            cnt_pre_nxt = pre_inc;
          end
        end
      end
      dart_pkg::MODE_READ: begin
        unique case (item.address)
          dart_pkg::ADDR_DIV:     rd = div_val_r;
          dart_pkg::ADDR_COUNT:   rd = count_r;
          dart_pkg::ADDR_MODULO:  rd = modulo_r;
          dart_pkg::ADDR_CONTROL: rd = control_r;
          default:                rd = 8'd0;
        endcase
      end
      dart_pkg::MODE_WRITE: begin
        unique case (item.address)
          dart_pkg::ADDR_DIV:     div_val_nxt = 8'd0;
          dart_pkg::ADDR_COUNT:   count_nxt   = item.write_data;
          dart_pkg::ADDR_MODULO:  modulo_nxt  = item.write_data;
          dart_pkg::ADDR_CONTROL: begin
            control_nxt = item.write_data;
            period_nxt  = dart_pkg::period_of(item.write_data[1:0]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res.read_data = rd;
  assign res.irq_pulse = irq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_val_r <= '0;
      div_pre_r <= '0;
      count_r   <= '0;
      modulo_r  <= '0;
      control_r <= '0;
      cnt_pre_r <= '0;
      period_r  <= '0;
    end else if (go) begin
      div_val_r <= div_val_nxt;
      div_pre_r <= div_pre_nxt;
      count_r   <= count_nxt;
      modulo_r  <= modulo_nxt;
      control_r <= control_nxt;
      cnt_pre_r <= cnt_pre_nxt;
      period_r  <= period_nxt;
    end
  end

  a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (go && irq) |=> (count_r == $past(modulo_r) && cnt_pre_r == '0))
    else $error("irq without counter reload");

  a_read_no_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.mode == dart_pkg::MODE_READ) |=>
      ($stable(div_val_r) && $stable(div_pre_r) && $stable(count_r) &&
       $stable(cnt_pre_r) && $stable(control_r)))
    else $error("read changed timer state");

  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.mode == dart_pkg::MODE_TICK && !control_r[dart_pkg::ENABLE_BIT]) |=>
      ($stable(cnt_pre_r) && $stable(count_r)))
    else $error("counter moved while disabled");

endmodule

`default_nettype wire

/* src/divider_and_reload_timer.sv */
`default_nettype none

// Divider and reload timer. Every word on the input channel is a tick, a
// register read, a register write or an unused mode, and each gives exactly one result word.
// One word is taken every cycle unless out_stall holds a full result register;
// each word passes through the input register, then the timer update and the
// result register. The rate is set by the update of the timer registers,
// which each word goes through in turn.
module divider_and_reload_timer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dart_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output dart_pkg::out_word_t out_data
);

  logic                in_vld_r;
  dart_pkg::in_word_t  in_data_r;
  logic                out_vld_r;
  dart_pkg::out_word_t out_data_r;
  dart_pkg::out_word_t res;
  logic                advance;

  // the held word moves on when the result register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  dart_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .item  (in_data_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sim/divider_and_reload_timer_tb.sv */
module divider_and_reload_timer_tb;

  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_WORDS = 750;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dart_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dart_pkg::out_word_t out_data;

  divider_and_reload_timer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // timer state as predicted from the accepted words
  logic [7:0]                      div_q, div_pre, cnt_q, mod_q, ctl_q;
  logic [dart_pkg::PRESCALE_W-1:0] cnt_pre, cnt_per;

  dart_pkg::out_word_t timer_results[$];
  int        error_count = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        irq_seen = 0;
  int        stall_cycles = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b0;

  function automatic logic [dart_pkg::PRESCALE_W-1:0] select_period(input logic [1:0] sel);
    case (sel)
      2'd0: return dart_pkg::PERIOD_SEL0;
      2'd1: return dart_pkg::PERIOD_SEL1;
      2'd2: return dart_pkg::PERIOD_SEL2;
      default: return dart_pkg::PERIOD_SEL3;
    endcase
  endfunction

  function automatic void timer_clear();
    div_q = '0; div_pre = '0; cnt_q = '0; mod_q = '0; ctl_q = '0;
    cnt_pre = '0; cnt_per = '0;
  endfunction

  function automatic dart_pkg::out_word_t timer_update(input dart_pkg::in_word_t w);
    dart_pkg::out_word_t r;
    r = '0;
    case (w.mode)
      dart_pkg::MODE_TICK: begin
        div_pre = div_pre + 8'd1;
        if (div_pre == 8'd0) div_q = div_q + 8'd1;
        if (ctl_q[dart_pkg::ENABLE_BIT]) begin
          cnt_pre = cnt_pre + 1'b1;
          if (cnt_pre == cnt_per) begin
            cnt_pre = '0;
            if (cnt_q == dart_pkg::COUNT_MAX) begin
              cnt_q = mod_q;
              r.irq_pulse = 1'b1;
            end else begin
              cnt_q = cnt_q + 8'd1;
            end
          end
        end
      end
      dart_pkg::MODE_READ: begin
        case (w.address)
          dart_pkg::ADDR_DIV:     r.read_data = div_q;
          dart_pkg::ADDR_COUNT:   r.read_data = cnt_q;
          dart_pkg::ADDR_MODULO:  r.read_data = mod_q;
          dart_pkg::ADDR_CONTROL: r.read_data = ctl_q;
          default:                r.read_data = 8'd0;
        endcase
      end
      dart_pkg::MODE_WRITE: begin
        case (w.address)
          dart_pkg::ADDR_DIV:     div_q = 8'd0;
          dart_pkg::ADDR_COUNT:   cnt_q = w.write_data;
          dart_pkg::ADDR_MODULO:  mod_q = w.write_data;
          dart_pkg::ADDR_CONTROL: begin
            ctl_q = w.write_data;
            cnt_per = select_period(w.write_data[1:0]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dart_pkg::in_word_t make_word(input logic [1:0] mode,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
    dart_pkg::in_word_t w;
    w.mode = mode;
    w.address = addr;
    w.write_data = data;
    return w;
  endfunction

  function automatic logic [15:0] any_timer_reg();
    case ($urandom_range(0, 3))
      0: return dart_pkg::ADDR_DIV;
      1: return dart_pkg::ADDR_COUNT;
      2: return dart_pkg::ADDR_MODULO;
      default: return dart_pkg::ADDR_CONTROL;
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  task automatic send_word(input dart_pkg::in_word_t w);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      // now and then a long burst with no idle cycles at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timer_results.push_back(timer_update(w));
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(make_word(dart_pkg::MODE_TICK, 16'($urandom), 8'($urandom)));
  endtask

  // hold the input until every expected word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (timer_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reset_values_test();
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_DIV, 8'hFF));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_COUNT, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_MODULO, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_CONTROL, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, 16'h0000, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, 16'hFFFF, 8'hFF));
    send_word(make_word(MODE_NONE, dart_pkg::ADDR_COUNT, 8'hFF));
    drain_results();
  endtask

  task automatic register_access_test();
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_MODULO, 8'hFF));
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_COUNT, 8'hFE));
    // enable clear: ticks must leave count alone
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL, 8'hFB));
    send_ticks(3);
    send_word(make_word(dart_pkg::MODE_WRITE, 16'hFF03, 8'h55));
    send_word(make_word(dart_pkg::MODE_WRITE, 16'hFF08, 8'hAA));
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_DIV, 8'hAA));
    send_word(make_word(MODE_NONE, dart_pkg::ADDR_CONTROL, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_DIV, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_COUNT, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_MODULO, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_CONTROL, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, 16'hFF03, 8'h00));
    drain_results();
  endtask

  // prescaler is kept across a period change, so the first step comes early
  task automatic period_change_test();
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_COUNT, 8'hFF));
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_MODULO, 8'h80));
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL, 8'h07));
    send_ticks(40);
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL, 8'h06));
    send_ticks(30);
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_COUNT, 8'h00));
    send_word(make_word(dart_pkg::MODE_READ, dart_pkg::ADDR_DIV, 8'h00));
    send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL, 8'h00));
    drain_results();
  endtask

  task automatic random_test();
    int start;
    int n;
    logic [1:0] sel;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // set up a running timer near overflow, then tick with reads mixed in
          sel = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd1;
          send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_MODULO, 8'($urandom)));
          send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL,
                              {5'($urandom), 1'b1, sel}));
          send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_COUNT,
                              8'($urandom_range(8'hF0, 8'hFF))));
          n = $urandom_range(20, 120);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0)
              send_word(make_word(dart_pkg::MODE_READ, any_timer_reg(), 8'($urandom)));
            else
              send_ticks(1);
          end
          if ($urandom_range(0, 2) == 0)
            send_word(make_word(dart_pkg::MODE_WRITE, dart_pkg::ADDR_CONTROL,
                                8'($urandom) & 8'hFB));
        end
        4, 5: send_ticks($urandom_range(1, 50));
        6: begin
          repeat ($urandom_range(1, 6))
            send_word(make_word(dart_pkg::MODE_READ, any_timer_reg(), 8'($urandom)));
        end
        7: send_word(make_word(dart_pkg::MODE_WRITE, any_timer_reg(), 8'($urandom)));
        default: begin
          repeat ($urandom_range(1, 4))
            send_word(make_word(2'($urandom), 16'($urandom), 8'($urandom)));
        end
      endcase
    end
    drain_results();
  endtask

  // result stall pattern, switching style whenever a random hold count runs out
  int stall_style = 0;
  int stall_left = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (timer_results.size() == 0) begin
        report_error($sformatf("result word with none expected: %0h", out_data));
      end else begin
        dart_pkg::out_word_t exp;
        exp = timer_results.pop_front();
        if (out_data.read_data !== exp.read_data)
          report_error($sformatf("read_data expected %02h got %02h",
                                 exp.read_data, out_data.read_data));
        if (out_data.irq_pulse !== exp.irq_pulse)
          report_error($sformatf("irq_pulse expected %0b got %0b",
                                 exp.irq_pulse, out_data.irq_pulse));
        if (out_data.irq_pulse === 1'b1) irq_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, timer_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    timer_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reset_values_test();
    register_access_test();
    gaps_on = 1'b1;
    period_change_test();
    random_test();
    while (timer_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words (ticks, reads, writes, unused mode), %0d results checked",
             words_sent, results_seen);
    $display("%0d counter reloads seen, %0d cycles of result stall", irq_seen, stall_cycles);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
